// ===== rtl/core/positional_doubly_linked_list_core_assert.svh =====
// Assertion macros for the positional linked list core
`ifndef POSITIONAL_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH
`define POSITIONAL_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PDL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PDL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PDL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PDL_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pdll_pkg.sv =====
// Shared types and codes for the positional linked list core
`timescale 1ns / 1ps
package pdll_pkg;
   localparam logic [6:0] NIL = 7'd127;
   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0, CMD_INS_END = 3'd1, CMD_INS_POS = 3'd2,
      CMD_DEL_FRONT = 3'd3, CMD_DEL_END = 3'd4, CMD_DEL_POS = 3'd5,
      CMD_PRINT = 3'd6, CMD_NONE = 3'd7
   } cmd_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_BADPOS = 2'd2, ST_FULL = 2'd3
   } status_type;
endpackage

// ===== rtl/core/positional_doubly_linked_list_core.sv =====
// Top level: linked list store, command sequencer and result register
//
// Ordered list of up to CAPACITY signed 32-bit values, held in synchronous
// memories with registered reads for values, forward links and backward
// links, plus a free-slot stack. One command at a time. Reaching position p
// walks the forward links, each entry taking an address state (S_WALK) and
// then a registered-read state (S_WALKW). An insert at the end walks the
// whole list. Delete at the front or the end starts from the head or the
// tail without a walk. Print sends one word per element, held by any stall
// on the result side. Rejected commands and an empty print go straight to
// the result state S_OUT.
// Results leave through a single output register; the next command is taken
// only once the current one has finished and its last word has been taken.
// No clearing pass is needed after reset: the free stack reads as slot
// order until written.
`timescale 1ns / 1ps
`include "positional_doubly_linked_list_core_assert.svh"
module positional_doubly_linked_list_core #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cmd[2:0], value[34:3], position[41:35], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], element[33:2], zero
   output logic        rsp_tlast
);
   import pdll_pkg::*;
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_WALK, S_WALKW, S_INS, S_INS2, S_DEL, S_DELW, S_DEL2,
      S_PRT, S_PRTW, S_OUT
   } state_type;

   logic [31:0]   val_mem  [CAPACITY];
   logic [6:0]    nxt_mem  [CAPACITY];
   logic [6:0]    prv_mem  [CAPACITY];
   logic [AW-1:0] free_mem [CAPACITY];
   logic [CAPACITY-1:0] free_wr_ff;

   state_type   state_ff;
   logic [2:0]  cmd_ff;
   logic [31:0] value_ff;
   logic [6:0]  pos_ff, cnt_ff, head_ff, tail_ff, cur_ff, idx_ff, bef_ff, new_ff;
   logic [AW-1:0] fslot_rd_ff;
   logic [6:0]  nxt_rd_ff, prv_rd_ff;
   logic [31:0] val_rd_ff;
   logic        rsp_valid_ff, rsp_last_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_elem_ff;
   logic        rsp_load;

   // memory ports
   logic [AW-1:0] rd_addr;
   logic          nwe, pwe, vwe, fwe;
   logic [AW-1:0] nwa, pwa, fwa;
   logic [6:0]    nwd, pwd;
   logic [AW-1:0] fra, fwd;

   logic [2:0]  in_cmd;
   logic [6:0]  in_pos;
   assign in_cmd = req_tdata[2:0];
   assign in_pos = req_tdata[41:35];
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_load = (state_ff == S_PRTW || state_ff == S_OUT) &&
                     (!rsp_valid_ff || rsp_tready);

   logic [6:0] cap7;
   assign cap7 = 7'(CAPACITY);
   logic [6:0] nfree;
   logic [6:0] nfree_m1;
   assign nfree = cap7 - cnt_ff;
   assign nfree_m1 = nfree - 7'd1;

   always_ff @(posedge clock) begin
      nxt_rd_ff <= nxt_mem[rd_addr];
      prv_rd_ff <= prv_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
      fslot_rd_ff <= free_wr_ff[fra] ? free_mem[fra] : AW'(CAPACITY - 1) - fra;
      if (nwe) nxt_mem[nwa] <= nwd;
      if (pwe) prv_mem[pwa] <= pwd;
      if (vwe) val_mem[new_ff[AW-1:0]] <= value_ff;
      if (fwe) free_mem[fwa] <= fwd;
   end
   assign fra = nfree_m1[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) free_wr_ff <= '0;
      else if (fwe) free_wr_ff[fwa] <= 1'b1;
   end

   // combinational control of the write ports
   always_comb begin
      rd_addr = cur_ff[AW-1:0];
      nwe = 1'b0; pwe = 1'b0; vwe = 1'b0; fwe = 1'b0;
      nwa = '0; pwa = '0; fwa = '0; nwd = NIL; pwd = NIL; fwd = '0;
      case (state_ff)
         S_INS: begin
            // new slot: value, links; neighbours fixed in S_INS2
            vwe = 1'b1;
            nwe = 1'b1; nwa = new_ff[AW-1:0];
            nwd = cur_ff;
            pwe = 1'b1; pwa = new_ff[AW-1:0]; pwd = bef_ff;
         end
         S_INS2: begin
            if (bef_ff != NIL) begin
               nwe = 1'b1; nwa = bef_ff[AW-1:0]; nwd = new_ff;
            end
            if (cur_ff != NIL) begin
               pwe = 1'b1; pwa = cur_ff[AW-1:0]; pwd = new_ff;
            end
         end
         S_DEL2: begin
            if (prv_rd_ff != NIL) begin
               nwe = 1'b1; nwa = prv_rd_ff[AW-1:0]; nwd = nxt_rd_ff;
            end
            if (nxt_rd_ff != NIL) begin
               pwe = 1'b1; pwa = nxt_rd_ff[AW-1:0]; pwd = prv_rd_ff;
            end
            fwe = 1'b1; fwa = nfree[AW-1:0]; fwd = cur_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         head_ff <= NIL;
         tail_ff <= NIL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               cmd_ff <= in_cmd;
               value_ff <= req_tdata[34:3];
               idx_ff <= '0;
               rsp_elem_ff <= '0;
               rsp_last_ff <= 1'b1;
               case (in_cmd)
                  CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS: begin
                     pos_ff <= (in_cmd == CMD_INS_FRONT) ? 7'd0 :
                               (in_cmd == CMD_INS_END) ? cnt_ff : in_pos;
                     if (cnt_ff >= cap7) begin
                        rsp_status_ff <= ST_FULL; state_ff <= S_OUT;
                     end else if (in_cmd == CMD_INS_POS && in_pos > cnt_ff) begin
                        rsp_status_ff <= ST_BADPOS; state_ff <= S_OUT;
                     end else begin
                        rsp_status_ff <= ST_OK;
                        cur_ff <= head_ff;
                        bef_ff <= NIL;
                        state_ff <= S_WALK;
                     end
                  end
                  CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS: begin
                     // the end is reached through the tail, at walk distance zero
                     pos_ff <= (in_cmd == CMD_DEL_POS) ? in_pos : 7'd0;
                     if (cnt_ff == 7'd0) begin
                        rsp_status_ff <= ST_EMPTY; state_ff <= S_OUT;
                     end else if (in_cmd == CMD_DEL_POS && in_pos >= cnt_ff) begin
                        rsp_status_ff <= ST_BADPOS; state_ff <= S_OUT;
                     end else begin
                        rsp_status_ff <= ST_OK;
                        cur_ff <= (in_cmd == CMD_DEL_END) ? tail_ff : head_ff;
                        state_ff <= S_WALK;
                     end
                  end
                  CMD_PRINT: begin
                     if (cnt_ff == 7'd0 || head_ff == NIL) begin
                        rsp_status_ff <= ST_EMPTY; state_ff <= S_OUT;
                     end else begin
                        rsp_status_ff <= ST_OK;
                        cur_ff <= head_ff;
                        state_ff <= S_PRT;
                     end
                  end
                  default: ;
               endcase
            end
            // walk: for insert, stop when idx == pos (cur = after, bef = before)
            S_WALK: begin
               if (idx_ff == pos_ff) begin
                  if (cmd_ff <= 3'(CMD_INS_POS)) begin
                     new_ff <= {1'b0, 6'(fslot_rd_ff)};
                     state_ff <= S_WALKW;
                  end else state_ff <= S_DEL;
               end else state_ff <= S_WALKW;
            end
            S_WALKW: begin
               if (idx_ff == pos_ff) begin
                  state_ff <= S_INS;
               end else begin
                  bef_ff <= cur_ff;
                  cur_ff <= nxt_rd_ff;
                  idx_ff <= idx_ff + 7'd1;
                  state_ff <= S_WALK;
               end
            end
            S_INS: begin
               // cur is the after slot
               state_ff <= S_INS2;
            end
            S_INS2: begin
               if (bef_ff == NIL) head_ff <= new_ff;
               if (cur_ff == NIL) tail_ff <= new_ff;
               cnt_ff <= cnt_ff + 7'd1;
               state_ff <= S_OUT;
            end
            S_DEL: state_ff <= S_DELW;
            S_DELW: state_ff <= S_DEL2;
            S_DEL2: begin
               if (prv_rd_ff == NIL) head_ff <= nxt_rd_ff;
               if (nxt_rd_ff == NIL) tail_ff <= prv_rd_ff;
               cnt_ff <= cnt_ff - 7'd1;
               state_ff <= S_OUT;
            end
            S_PRT: state_ff <= S_PRTW;
            S_PRTW: if (rsp_load) begin
               rsp_status_ff <= ST_OK;
               rsp_elem_ff <= val_rd_ff;
               if (nxt_rd_ff == NIL || idx_ff + 7'd1 >= cnt_ff) begin
                  rsp_last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  rsp_last_ff <= 1'b0;
                  cur_ff <= nxt_rd_ff;
                  idx_ff <= idx_ff + 7'd1;
                  state_ff <= S_PRT;
               end
            end
            S_OUT: if (rsp_load) begin
               rsp_last_ff <= 1'b1;
               rsp_elem_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_elem_ff, rsp_status_ff};

   `PDL_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= cap7, "count beyond capacity")
   `PDL_ASSERT_IMP(a_empty_ends, clock, reset, cnt_ff == 7'd0,
      head_ff == NIL && tail_ff == NIL, "empty list with linked ends")
   `PDL_ASSERT_NXT(a_hold_rsp, clock, reset, rsp_valid_ff && !rsp_tready,
      rsp_valid_ff && $stable(rsp_tdata), "result word dropped")
endmodule
